[design/mfs_pkg.sv]
// shared types and constants of the multilevel feedback scheduler
// no dependencies; used by multilevel_feedback_scheduler_unit
package mfs_pkg;

	localparam int N_LEVELS    = 4;
	localparam int QUEUE_DEPTH = 16;

	localparam int LEVEL_W = (N_LEVELS > 1) ? $clog2(N_LEVELS) : 1;
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W  = (N_LEVELS * QUEUE_DEPTH > 1) ? $clog2(N_LEVELS * QUEUE_DEPTH) : 1;
	localparam int ID_W    = 8;
	localparam int TIME_W  = 16;
	localparam int ENTRY_W = ID_W + TIME_W;

	localparam logic [LEVEL_W-1:0] LEVEL_LAST = LEVEL_W'(N_LEVELS - 1);
	localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [TIME_W-1:0]  SLICE_MAX  = '1;

	typedef struct packed {
		logic              arrival_valid;
		logic [ID_W-1:0]   arrival_id;
		logic [TIME_W-1:0] arrival_burst;
	} mfs_in_t;

	typedef struct packed {
		logic            run_valid;
		logic [ID_W-1:0] run_id;
		logic [2:0]      run_level;
		logic            task_finished;
		logic            idle;
		logic            queue_overflow;
	} mfs_out_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] remaining;
	} mfs_entry_t;

endpackage

[design/mfs_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/multilevel_feedback_scheduler_unit.sv]
// multilevel feedback queue scheduler, one tick per accepted beat
// depends on mfs_pkg and mfs_ram
//
// Each beat is one scheduler tick and runs through the accept cycle (slice
// expiry and demotion write), the arrival write, the queue selection with
// its read of the queue ram, and the execute cycle that uses the read data.
// The single queue ram, written and read in separate cycles, sets this order.
// The result appears on result for one cycle with done high, the cycle after
// the execute cycle, and must be taken then; a new start is accepted in that
// same cycle. busy is high from the arrival write through the execute cycle.
// Queue entries live only in the ram, so no clearing pass is needed.
module multilevel_feedback_scheduler_unit
	import mfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  mfs_in_t  arrival,
	output logic     done,
	output mfs_out_t result
);

	typedef enum logic [1:0] {ST_IDLE, ST_ARRIVE, ST_SELECT, ST_EXEC} state_t;

	typedef struct packed {
		logic               free;
		logic               found;
		logic [LEVEL_W-1:0] lvl;
	} mfs_sel_t;

	state_t state_q;

	logic [PTR_W-1:0] head_q  [N_LEVELS];
	logic [PTR_W-1:0] tail_q  [N_LEVELS];
	logic [CNT_W-1:0] count_q [N_LEVELS];

	logic               cpu_busy_q;
	logic [ID_W-1:0]    cpu_id_q;
	logic [TIME_W-1:0]  cpu_rem_q;
	logic [LEVEL_W-1:0] cpu_level_q;
	logic [TIME_W-1:0]  slice_q;

	mfs_in_t  arr_q;
	logic     ovf_q;
	mfs_sel_t sel_s1;
	mfs_out_t res_q;
	logic     done_q;

	logic accept;
	logic dem_need;
	logic dem_last;

	logic               push_req;
	logic [LEVEL_W-1:0] push_lvl;
	logic               push_full;
	mfs_entry_t         push_entry;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;

	logic               sel_free;
	logic               sel_found;
	logic [LEVEL_W-1:0] sel_lvl;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	mfs_entry_t         rd_entry;

	logic               e_busy;
	logic [ID_W-1:0]    e_id;
	logic [TIME_W-1:0]  e_rem;
	logic [LEVEL_W-1:0] e_lvl;
	logic [TIME_W-1:0]  e_slice;
	logic [TIME_W-1:0]  x_rem;
	logic               x_fin;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// slice of 2^level ticks used up by a task that still has work
	assign dem_need = cpu_busy_q && (cpu_rem_q != '0)
		&& (slice_q >= (TIME_W'(1) << cpu_level_q));
	assign dem_last = (cpu_level_q >= LEVEL_LAST);

	always_comb begin
		push_req   = 1'b0;
		push_lvl   = '0;
		push_entry = '{id: arr_q.arrival_id, remaining: arr_q.arrival_burst};
		if (accept && dem_need && !dem_last) begin
			push_req   = 1'b1;
			push_lvl   = cpu_level_q + LEVEL_W'(1);
			push_entry = '{id: cpu_id_q, remaining: cpu_rem_q};
		end else if (state_q == ST_ARRIVE && arr_q.arrival_valid) begin
			push_req = 1'b1;
		end
	end

	assign push_full = (count_q[push_lvl] >= CNT_FULL);
	assign ram_we    = push_req && !push_full;
	assign ram_waddr = ADDR_W'(push_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[push_lvl]);

	// lowest non-empty level wins
	always_comb begin
		sel_found = 1'b0;
		sel_lvl   = '0;
		for (int l = N_LEVELS - 1; l >= 0; l--) begin
			if (count_q[l] != '0) begin
				sel_found = 1'b1;
				sel_lvl   = LEVEL_W'(l);
			end
		end
	end

	assign sel_free  = !cpu_busy_q || (cpu_rem_q == '0);
	assign ram_raddr = ADDR_W'(sel_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[sel_lvl]);

	mfs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (N_LEVELS * QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (push_entry),
		.re    ((state_q == ST_SELECT) && sel_free && sel_found),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = ram_rdata;

	// processor slot as seen by the execute step
	always_comb begin
		e_busy  = cpu_busy_q;
		e_id    = cpu_id_q;
		e_rem   = cpu_rem_q;
		e_lvl   = cpu_level_q;
		e_slice = slice_q;
		if (sel_s1.free) begin
			e_busy  = sel_s1.found;
			e_slice = '0;
			if (sel_s1.found) begin
				e_id  = rd_entry.id;
				e_rem = rd_entry.remaining;
				e_lvl = sel_s1.lvl;
			end
		end
		x_rem = (e_rem != '0) ? e_rem - TIME_W'(1) : '0;
		x_fin = (x_rem == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			cpu_busy_q  <= 1'b0;
			cpu_id_q    <= '0;
			cpu_rem_q   <= '0;
			cpu_level_q <= '0;
			slice_q     <= '0;
			ovf_q       <= 1'b0;
			sel_s1      <= '0;
			arr_q       <= '0;
			res_q       <= '0;
			for (int l = 0; l < N_LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			done_q <= 1'b0;

			if (push_req) begin
				if (push_full) begin
					ovf_q <= 1'b1;
				end else begin
					tail_q[push_lvl]  <= (tail_q[push_lvl] == PTR_LAST) ? '0
						: tail_q[push_lvl] + PTR_W'(1);
					count_q[push_lvl] <= count_q[push_lvl] + CNT_W'(1);
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ARRIVE;
						arr_q   <= arrival;
						if (!(dem_need && !dem_last && push_full)) begin
							ovf_q <= 1'b0;
						end
						if (dem_need) begin
							if (dem_last) begin
								slice_q <= '0;
							end else begin
								cpu_busy_q <= 1'b0;
							end
						end
					end
				end
				ST_ARRIVE: begin
					state_q <= ST_SELECT;
				end
				ST_SELECT: begin
					state_q <= ST_EXEC;
					sel_s1  <= '{free: sel_free, found: sel_found, lvl: sel_lvl};
					if (sel_free && sel_found) begin
						head_q[sel_lvl]  <= (head_q[sel_lvl] == PTR_LAST) ? '0
							: head_q[sel_lvl] + PTR_W'(1);
						count_q[sel_lvl] <= count_q[sel_lvl] - CNT_W'(1);
					end
				end
				ST_EXEC: begin
					state_q     <= ST_IDLE;
					done_q      <= 1'b1;
					cpu_id_q    <= e_id;
					cpu_level_q <= e_lvl;
					if (e_busy) begin
						cpu_rem_q  <= x_rem;
						cpu_busy_q <= !x_fin;
						slice_q    <= (e_slice < SLICE_MAX) ? e_slice + TIME_W'(1) : e_slice;
					end else begin
						cpu_rem_q  <= e_rem;
						cpu_busy_q <= 1'b0;
						slice_q    <= e_slice;
					end
					// result beat register
					res_q.run_valid      <= e_busy;
					res_q.run_id         <= e_busy ? e_id : '0;
					res_q.run_level      <= e_busy ? 3'(e_lvl) : 3'd0;
					res_q.task_finished  <= e_busy && x_fin;
					res_q.idle           <= !e_busy;
					res_q.queue_overflow <= ovf_q;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/sv/tb_multilevel_feedback_scheduler_unit.sv]
// testbench for multilevel_feedback_scheduler_unit: directed table, then random ticks,
// each result checked field by field against a fixed expected value or an in-bench scheduler model
// depends on mfs_pkg and the design sources
`timescale 1ns / 100ps

module tb_multilevel_feedback_scheduler_unit;
	import mfs_pkg::*;

	typedef struct {
		mfs_in_t  stim;
		bit       fixed;
		mfs_out_t want;
	} tick_row_t;

	localparam mfs_out_t IDLE_RESULT = mfs_out_t'{1'b0, 8'h00, 3'd0, 1'b0, 1'b1, 1'b0};

	logic     clk;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	mfs_in_t  arrival = '0;
	logic     done;
	mfs_out_t result;

	// scheduler model state
	mfs_entry_t        lvl_store [N_LEVELS][QUEUE_DEPTH];
	int                lvl_head  [N_LEVELS];
	int                lvl_tail  [N_LEVELS];
	int                lvl_count [N_LEVELS];
	bit                cpu_busy;
	logic [ID_W-1:0]   cpu_id;
	logic [TIME_W-1:0] cpu_rem;
	int                cpu_lvl;
	int                slice_used;

	mfs_out_t expected_runs[$];
	int       mismatch_count = 0;

	multilevel_feedback_scheduler_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.arrival (arrival),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// returns 1 when the level queue is full or the level is out of range, and the entry is lost
	function automatic bit level_push(int lvl, mfs_entry_t e);
		if (lvl >= N_LEVELS || lvl_count[lvl] >= QUEUE_DEPTH)
			return 1'b1;
		lvl_store[lvl][lvl_tail[lvl]] = e;
		lvl_tail[lvl] = (lvl_tail[lvl] + 1) % QUEUE_DEPTH;
		lvl_count[lvl]++;
		return 1'b0;
	endfunction

	function automatic mfs_out_t schedule_tick(mfs_in_t a);
		mfs_out_t   r;
		bit         ovf;
		mfs_entry_t e;
		r = '0;
		ovf = 1'b0;
		// slice used up: demote, or restart the count at the last level
		if (cpu_busy && cpu_rem != 0 && slice_used >= (1 << cpu_lvl)) begin
			if (cpu_lvl >= N_LEVELS - 1) begin
				slice_used = 0;
			end else begin
				if (level_push(cpu_lvl + 1, mfs_entry_t'{cpu_id, cpu_rem}))
					ovf = 1'b1;
				cpu_busy = 1'b0;
			end
		end
		if (a.arrival_valid) begin
			if (level_push(0, mfs_entry_t'{a.arrival_id, a.arrival_burst}))
				ovf = 1'b1;
		end
		if (!cpu_busy || cpu_rem == 0) begin
			cpu_busy = 1'b0;
			for (int l = 0; l < N_LEVELS && !cpu_busy; l++) begin
				if (lvl_count[l] != 0) begin
					e = lvl_store[l][lvl_head[l]];
					lvl_head[l] = (lvl_head[l] + 1) % QUEUE_DEPTH;
					lvl_count[l]--;
					cpu_id = e.id;
					cpu_rem = e.remaining;
					cpu_lvl = l;
					cpu_busy = 1'b1;
				end
			end
			slice_used = 0;
		end
		if (cpu_busy) begin
			// a zero burst still runs for one tick
			if (cpu_rem != 0)
				cpu_rem--;
			r.run_valid = 1'b1;
			r.run_id = cpu_id;
			r.run_level = 3'(cpu_lvl);
			r.task_finished = (cpu_rem == 0);
			if (cpu_rem == 0)
				cpu_busy = 1'b0;
			if (slice_used < 65535)
				slice_used++;
		end else begin
			r.idle = 1'b1;
		end
		r.queue_overflow = ovf;
		return r;
	endfunction

	// one beat: optional idle gap, then hold start until accepted
	task automatic drive_tick(mfs_in_t item, int idle_pct, bit fixed, mfs_out_t want);
		int       gap;
		mfs_out_t pred;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(6, 1) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		arrival <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pred = schedule_tick(item);
		expected_runs.push_back(fixed ? want : pred);
	endtask

	task automatic report_field(string field, int got, int want);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %0h, got %0h", field, want, got);
	endtask

	always @(posedge clk) begin
		mfs_out_t want;
		if (arst_n && done) begin
			if (expected_runs.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with no tick pending: %p", result);
			end else begin
				want = expected_runs.pop_front();
				if (result.run_valid !== want.run_valid)
					report_field("run_valid", result.run_valid, want.run_valid);
				if (result.run_id !== want.run_id)
					report_field("run_id", result.run_id, want.run_id);
				if (result.run_level !== want.run_level)
					report_field("run_level", result.run_level, want.run_level);
				if (result.task_finished !== want.task_finished)
					report_field("task_finished", result.task_finished, want.task_finished);
				if (result.idle !== want.idle)
					report_field("idle", result.idle, want.idle);
				if (result.queue_overflow !== want.queue_overflow)
					report_field("queue_overflow", result.queue_overflow, want.queue_overflow);
			end
		end
	end

	initial begin
		tick_row_t rows[$];
		mfs_in_t   item;
		int        rate;
		int        idle_pct;
		int        pick;

		for (int l = 0; l < N_LEVELS; l++) begin
			lvl_head[l] = 0;
			lvl_tail[l] = 0;
			lvl_count[l] = 0;
		end
		cpu_busy = 1'b0;
		cpu_id = '0;
		cpu_rem = '0;
		cpu_lvl = 0;
		slice_used = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing queued after reset
		rows.push_back(tick_row_t'{mfs_in_t'{1'b0, 8'h00, 16'h0000}, 1'b1, IDLE_RESULT});
		// zero burst runs one tick and finishes
		rows.push_back(tick_row_t'{mfs_in_t'{1'b1, 8'hA5, 16'h0000}, 1'b1,
			mfs_out_t'{1'b1, 8'hA5, 3'd0, 1'b1, 1'b0, 1'b0}});
		// fields carry values but valid is low
		rows.push_back(tick_row_t'{mfs_in_t'{1'b0, 8'hFF, 16'hFFFF}, 1'b1, IDLE_RESULT});
		// two-tick tasks each demoted once: level 1 fills up
		for (int i = 0; i < QUEUE_DEPTH; i++)
			rows.push_back(tick_row_t'{mfs_in_t'{1'b1, 8'(8'h10 + i), 16'd2}, 1'b0, '0});
		// longest burst, then its demotion meets a full level 1 and is dropped
		rows.push_back(tick_row_t'{mfs_in_t'{1'b1, 8'hFF, 16'hFFFF}, 1'b0, '0});
		rows.push_back(tick_row_t'{mfs_in_t'{1'b0, 8'h00, 16'h0000}, 1'b0, '0});
		rows.push_back(tick_row_t'{mfs_in_t'{1'b1, 8'h00, 16'h0001}, 1'b0, '0});

		foreach (rows[i])
			drive_tick(rows[i].stim, 11, rows[i].fixed, rows[i].want);

		rate = 50;
		for (int i = 0; i < 600; i++) begin
			// arrival rate is redrawn at random every 40 beats, anywhere from sparse to saturating
			if (i % 40 == 0) begin
				case ($urandom_range(4))
					0: rate = 5;
					1: rate = 30;
					2: rate = 60;
					3: rate = 90;
					default: rate = 100;
				endcase
			end
			idle_pct = (i < 200) ? 11 : (i < 400) ? 55 : 0;
			item.arrival_valid = ($urandom_range(99) < rate);
			item.arrival_id = 8'($urandom_range(255));
			pick = $urandom_range(99);
			// mostly short bursts so tasks finish and move through all levels
			if (pick < 5)
				item.arrival_burst = '0;
			else if (pick < 9)
				item.arrival_burst = 16'($urandom_range(300, 60));
			else
				item.arrival_burst = 16'($urandom_range(24, 1));
			drive_tick(item, idle_pct, 1'b0, '0);
		end
		start <= 1'b0;

		while (expected_runs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
